@@ hdl/segment_intersection_test_unit_defines.svh @@
// Assertion macros for the segment intersection test unit.
`ifndef SEGMENT_INTERSECTION_TEST_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`define SIT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`else
`define SIT_ASSERT_NEXT(label, clk, rst, ante, cons)
`define SIT_ASSERT_SAME(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/sit_pkg.sv @@
`timescale 1ns / 1ps

package sit_pkg;

   localparam int COORD_BITS = 24;
   localparam int ID_BITS    = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int DET_BITS   = PROD_BITS + 1;

   localparam int REQ_RAW_BITS  = 4 * ID_BITS + 8 * COORD_BITS;
   localparam int REQ_DATA_BITS = ((REQ_RAW_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 8;
   localparam int ORIENT_COUNT  = 4;

   typedef logic        [ID_BITS-1:0]    id_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [DET_BITS-1:0]   det_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      diff_type x;
      diff_type y;
   } vec_type;

   typedef struct packed {
      id_type    a_id;
      id_type    b_id;
      id_type    c_id;
      id_type    d_id;
      point_type a;
      point_type b;
      point_type c;
      point_type d;
   } seg_pair_type;

   typedef struct packed {
      vec_type   [ORIENT_COUNT-1:0] u;
      vec_type   [ORIENT_COUNT-1:0] v;
      point_type a_lo;
      point_type a_hi;
      point_type c_lo;
      point_type c_hi;
      logic      shared_id;
   } prep_type;

   typedef struct packed {
      prod_type [2*ORIENT_COUNT-1:0] prod;
      logic     box_meet;
      logic     shared_id;
   } prod_stage_type;

   typedef struct packed {
      logic [ORIENT_COUNT-1:0] neg;
      logic [ORIENT_COUNT-1:0] zero;
      logic                    box_meet;
      logic                    shared_id;
   } sign_type;

   function automatic vec_type vec_sub(point_type p, point_type o);
      vec_type r;
      r.x = diff_type'(p.x) - diff_type'(o.x);
      r.y = diff_type'(p.y) - diff_type'(o.y);
      return r;
   endfunction

endpackage

@@ hdl/sit_prep.sv @@
`timescale 1ns / 1ps

module sit_prep import sit_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  seg_pair_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output prep_type     out_data
);

   logic     valid_ff;
   logic     valid_in;
   prep_type data_ff;
   prep_type data_in;
   logic     load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !out_ready);

   always_comb begin
      data_in.u[0] = vec_sub(in_data.b, in_data.a);
      data_in.v[0] = vec_sub(in_data.c, in_data.a);
      data_in.u[1] = vec_sub(in_data.b, in_data.a);
      data_in.v[1] = vec_sub(in_data.d, in_data.a);
      data_in.u[2] = vec_sub(in_data.d, in_data.c);
      data_in.v[2] = vec_sub(in_data.a, in_data.c);
      data_in.u[3] = vec_sub(in_data.d, in_data.c);
      data_in.v[3] = vec_sub(in_data.b, in_data.c);

      data_in.a_lo.x = (in_data.a.x < in_data.b.x) ? in_data.a.x : in_data.b.x;
      data_in.a_hi.x = (in_data.a.x < in_data.b.x) ? in_data.b.x : in_data.a.x;
      data_in.a_lo.y = (in_data.a.y < in_data.b.y) ? in_data.a.y : in_data.b.y;
      data_in.a_hi.y = (in_data.a.y < in_data.b.y) ? in_data.b.y : in_data.a.y;
      data_in.c_lo.x = (in_data.c.x < in_data.d.x) ? in_data.c.x : in_data.d.x;
      data_in.c_hi.x = (in_data.c.x < in_data.d.x) ? in_data.d.x : in_data.c.x;
      data_in.c_lo.y = (in_data.c.y < in_data.d.y) ? in_data.c.y : in_data.d.y;
      data_in.c_hi.y = (in_data.c.y < in_data.d.y) ? in_data.d.y : in_data.c.y;

      data_in.shared_id = (in_data.a_id == in_data.b_id) || (in_data.a_id == in_data.c_id) ||
                          (in_data.a_id == in_data.d_id) || (in_data.b_id == in_data.c_id) ||
                          (in_data.b_id == in_data.d_id) || (in_data.c_id == in_data.d_id);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hdl/sit_orient.sv @@
`timescale 1ns / 1ps

module sit_orient import sit_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  prep_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output sign_type out_data
);

   // product stage
   logic           prod_valid_ff;
   logic           prod_valid_in;
   prod_stage_type prod_ff;
   prod_stage_type prod_in;
   logic           prod_load;
   logic           prod_ready;

   // sign stage
   logic     sign_valid_ff;
   logic     sign_valid_in;
   sign_type sign_ff;
   sign_type sign_in;
   logic     sign_load;
   det_type  det [ORIENT_COUNT];

   assign prod_ready    = !sign_valid_ff || out_ready;
   assign in_ready      = !prod_valid_ff || prod_ready;
   assign prod_load     = in_valid && in_ready;
   assign prod_valid_in = prod_load ? 1'b1 : (prod_valid_ff && !prod_ready);

   always_comb begin
      for (int k = 0; k < ORIENT_COUNT; k++) begin
         prod_in.prod[2*k]   = prod_type'(in_data.u[k].x) * prod_type'(in_data.v[k].y);
         prod_in.prod[2*k+1] = prod_type'(in_data.u[k].y) * prod_type'(in_data.v[k].x);
      end
      prod_in.box_meet  = (in_data.a_lo.x <= in_data.c_hi.x) && (in_data.c_lo.x <= in_data.a_hi.x) &&
                          (in_data.a_lo.y <= in_data.c_hi.y) && (in_data.c_lo.y <= in_data.a_hi.y);
      prod_in.shared_id = in_data.shared_id;
   end

   assign sign_load     = prod_valid_ff && prod_ready;
   assign sign_valid_in = sign_load ? 1'b1 : (sign_valid_ff && !out_ready);

   always_comb begin
      for (int k = 0; k < ORIENT_COUNT; k++) begin
         det[k]          = det_type'(prod_ff.prod[2*k]) - det_type'(prod_ff.prod[2*k+1]);
         sign_in.neg[k]  = det[k][DET_BITS-1];
         sign_in.zero[k] = (det[k] == '0);
      end
      sign_in.box_meet  = prod_ff.box_meet;
      sign_in.shared_id = prod_ff.shared_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sign_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         sign_valid_ff <= sign_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_ff <= prod_in;
      end
      if (sign_load) begin
         sign_ff <= sign_in;
      end
   end

   assign out_valid = sign_valid_ff;
   assign out_data  = sign_ff;

endmodule

@@ hdl/sit_decide.sv @@
`timescale 1ns / 1ps

module sit_decide import sit_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  sign_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output logic     crosses
);

   logic valid_ff;
   logic valid_in;
   logic crosses_ff;
   logic crosses_in;
   logic load;
   logic collinear;
   logic split_first;
   logic split_second;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !out_ready);

   always_comb begin
      collinear    = in_data.zero[2] && in_data.zero[3];
      split_first  = (in_data.neg[0] != in_data.neg[1]) || (in_data.zero[0] != in_data.zero[1]);
      split_second = (in_data.neg[2] != in_data.neg[3]) || (in_data.zero[2] != in_data.zero[3]);
      if (in_data.shared_id) begin
         crosses_in = 1'b0;
      end else if (collinear) begin
         crosses_in = in_data.box_meet;
      end else begin
         crosses_in = split_first && split_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         crosses_ff <= crosses_in;
      end
   end

   assign out_valid = valid_ff;
   assign crosses   = crosses_ff;

endmodule

@@ hdl/segment_intersection_test_unit.sv @@
`timescale 1ns / 1ps
// Segment intersection test unit.
// Input channel req_*: one beat carries two segments, four endpoint ids and
// the signed x/y coordinates of the four endpoints. Result channel rsp_*:
// one beat per input beat, in order, with the crosses flag in bit 0.
// A pair that shares any endpoint id never crosses. A first segment lying on
// the line of the second crosses when the bounding boxes touch; otherwise the
// segments cross when each straddles the other's line (touching counts).
// Pipeline stages, in order: difference stage, product stage (eight 25x25
// multipliers), determinant sign stage, output register. Throughput: one
// pair per cycle while rsp_tready is high.
// Each stage holds a valid bit and advances when the stage after it is empty
// or advancing, so bubbles close up while rsp_tready is low; with the
// pipeline full, req_tready drops and every beat is held, none lost.
// Reset (synchronous, active high) empties the pipeline; no state survives
// between beats.
`include "segment_intersection_test_unit_defines.svh"

module segment_intersection_test_unit import sit_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // first_from_id, first_to_id, second_from_id, second_to_id,
   // first_from_x, first_from_y, first_to_x, first_to_y,
   // second_from_x, second_from_y, second_to_x, second_to_y
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // crosses, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int CoordBase = 4 * ID_BITS;

   seg_pair_type pair;
   logic         s1_valid;
   logic         s1_ready;
   prep_type     s1_data;
   logic         s3_valid;
   logic         s3_ready;
   sign_type     s3_data;
   logic         crosses;

   always_comb begin
      pair.a_id = req_tdata[0*ID_BITS +: ID_BITS];
      pair.b_id = req_tdata[1*ID_BITS +: ID_BITS];
      pair.c_id = req_tdata[2*ID_BITS +: ID_BITS];
      pair.d_id = req_tdata[3*ID_BITS +: ID_BITS];
      pair.a.x  = req_tdata[CoordBase + 0*COORD_BITS +: COORD_BITS];
      pair.a.y  = req_tdata[CoordBase + 1*COORD_BITS +: COORD_BITS];
      pair.b.x  = req_tdata[CoordBase + 2*COORD_BITS +: COORD_BITS];
      pair.b.y  = req_tdata[CoordBase + 3*COORD_BITS +: COORD_BITS];
      pair.c.x  = req_tdata[CoordBase + 4*COORD_BITS +: COORD_BITS];
      pair.c.y  = req_tdata[CoordBase + 5*COORD_BITS +: COORD_BITS];
      pair.d.x  = req_tdata[CoordBase + 6*COORD_BITS +: COORD_BITS];
      pair.d.y  = req_tdata[CoordBase + 7*COORD_BITS +: COORD_BITS];
   end

   sit_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (pair),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   sit_orient u_orient (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   sit_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .crosses   (crosses)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS-1){1'b0}}, crosses};

   `SIT_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_tvalid)
   `SIT_ASSERT_NEXT(a_shared_id_clear, clock, reset, s3_valid && s3_ready && s3_data.shared_id, !rsp_tdata[0])
   `SIT_ASSERT_NEXT(a_prep_holds, clock, reset, s1_valid && !s1_ready, s1_valid && $stable(s1_data))
   `SIT_ASSERT_SAME(a_full_blocks, clock, reset, rsp_tvalid && !rsp_tready && s3_valid, !s3_ready)

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import sit_pkg::*;

   localparam int COORD_MIN = -8388608;
   localparam int COORD_MAX = 8388607;
   localparam int RANDOM_PAIRS = 430;
   localparam int IDLE_LIMIT = 2000;
   localparam int COORD_BASE = 4 * ID_BITS;

   typedef struct packed {
      id_type [3:0] id;
      point_type    a;
      point_type    b;
      point_type    c;
      point_type    d;
   } segment_pair_type;

   typedef struct {
      segment_pair_type pair;
      bit               known;
      bit               want;
   } stimulus_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // first_from_id, first_to_id, second_from_id, second_to_id,
   // first_from_x, first_from_y, first_to_x, first_to_y,
   // second_from_x, second_from_y, second_to_x, second_to_y
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // crosses, zero fill
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   bit               pending_crosses[$];
   stimulus_row_type directed_rows[$];
   int               fail_count = 0;
   bit               send_calm = 1'b0;

   segment_intersection_test_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic point_type make_point(int x, int y);
      point_type p;
      p.x = coord_type'(x);
      p.y = coord_type'(y);
      return p;
   endfunction

   function automatic stimulus_row_type row(bit known, bit want, int i0, int i1, int i2, int i3,
                                            int ax, int ay, int bx, int by,
                                            int cx, int cy, int dx, int dy);
      stimulus_row_type r;
      r.known = known;
      r.want = want;
      r.pair.id[0] = id_type'(i0);
      r.pair.id[1] = id_type'(i1);
      r.pair.id[2] = id_type'(i2);
      r.pair.id[3] = id_type'(i3);
      r.pair.a = make_point(ax, ay);
      r.pair.b = make_point(bx, by);
      r.pair.c = make_point(cx, cy);
      r.pair.d = make_point(dx, dy);
      return r;
   endfunction

   function automatic void add_row(stimulus_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic logic [REQ_DATA_BITS-1:0] pack_pair(segment_pair_type s);
      logic [REQ_DATA_BITS-1:0] w;
      w = '0;
      for (int k = 0; k < 4; k++)
         w[k*ID_BITS +: ID_BITS] = s.id[k];
      w[COORD_BASE + 0*COORD_BITS +: COORD_BITS] = s.a.x;
      w[COORD_BASE + 1*COORD_BITS +: COORD_BITS] = s.a.y;
      w[COORD_BASE + 2*COORD_BITS +: COORD_BITS] = s.b.x;
      w[COORD_BASE + 3*COORD_BITS +: COORD_BITS] = s.b.y;
      w[COORD_BASE + 4*COORD_BITS +: COORD_BITS] = s.c.x;
      w[COORD_BASE + 5*COORD_BITS +: COORD_BITS] = s.c.y;
      w[COORD_BASE + 6*COORD_BITS +: COORD_BITS] = s.d.x;
      w[COORD_BASE + 7*COORD_BITS +: COORD_BITS] = s.d.y;
      return w;
   endfunction

   function automatic longint orientation(point_type o, point_type p, point_type q);
      longint ux, uy, vx, vy;
      ux = longint'($signed(p.x)) - longint'($signed(o.x));
      uy = longint'($signed(p.y)) - longint'($signed(o.y));
      vx = longint'($signed(q.x)) - longint'($signed(o.x));
      vy = longint'($signed(q.y)) - longint'($signed(o.y));
      return ux * vy - uy * vx;
   endfunction

   function automatic int sign_of(longint v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
   endfunction

   function automatic bit spans_meet(longint p0, longint p1, longint q0, longint q1);
      longint lo, hi;
      lo = (p0 < p1) ? p0 : p1;
      if (((q0 < q1) ? q0 : q1) > lo) lo = (q0 < q1) ? q0 : q1;
      hi = (p0 > p1) ? p0 : p1;
      if (((q0 > q1) ? q0 : q1) < hi) hi = (q0 > q1) ? q0 : q1;
      return lo <= hi;
   endfunction

   function automatic bit predict_crosses(segment_pair_type s);
      bit shared;
      shared = 1'b0;
      for (int i = 0; i < 4; i++)
         for (int j = i + 1; j < 4; j++)
            if (s.id[i] == s.id[j]) shared = 1'b1;
      if (shared) return 1'b0;
      if (orientation(s.c, s.a, s.d) == 0 && orientation(s.c, s.b, s.d) == 0)
         return spans_meet($signed(s.a.x), $signed(s.b.x), $signed(s.c.x), $signed(s.d.x))
             && spans_meet($signed(s.a.y), $signed(s.b.y), $signed(s.c.y), $signed(s.d.y));
      return (sign_of(orientation(s.a, s.b, s.c)) != sign_of(orientation(s.a, s.b, s.d)))
          && (sign_of(orientation(s.c, s.d, s.a)) != sign_of(orientation(s.c, s.d, s.b)));
   endfunction

   function automatic int rand_span(int n);
      return int'($urandom_range(0, 2 * n)) - n;
   endfunction

   function automatic int edge_coord();
      case ($urandom_range(0, 5))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return int'(coord_type'($urandom()));
      endcase
   endfunction

   function automatic segment_pair_type random_pair();
      segment_pair_type s;
      int               mode, cx, cy, dx, dy, i, j;
      int               t[4];
      bit               clash;
      mode = $urandom_range(0, 99);
      do begin
         for (int k = 0; k < 4; k++) s.id[k] = id_type'($urandom());
         clash = 1'b0;
         for (int p = 0; p < 4; p++)
            for (int q = p + 1; q < 4; q++)
               if (s.id[p] == s.id[q]) clash = 1'b1;
      end while (clash);
      if (mode < 30) begin
         s.a = make_point(int'(coord_type'($urandom())), int'(coord_type'($urandom())));
         s.b = make_point(int'(coord_type'($urandom())), int'(coord_type'($urandom())));
         s.c = make_point(int'(coord_type'($urandom())), int'(coord_type'($urandom())));
         s.d = make_point(int'(coord_type'($urandom())), int'(coord_type'($urandom())));
      end else if (mode < 55) begin
         cx = rand_span(8388000);
         cy = rand_span(8388000);
         s.a = make_point(cx + rand_span(16), cy + rand_span(16));
         s.b = make_point(cx + rand_span(16), cy + rand_span(16));
         s.c = make_point(cx + rand_span(16), cy + rand_span(16));
         s.d = make_point(cx + rand_span(16), cy + rand_span(16));
      end else if (mode < 75) begin
         cx = rand_span(1048576);
         cy = rand_span(1048576);
         dx = rand_span(300);
         dy = rand_span(300);
         for (int k = 0; k < 4; k++) t[k] = rand_span(40);
         if ($urandom_range(0, 4) == 0) t[3] = t[2];
         s.a = make_point(cx + t[0] * dx, cy + t[0] * dy);
         s.b = make_point(cx + t[1] * dx, cy + t[1] * dy);
         s.c = make_point(cx + t[2] * dx, cy + t[2] * dy);
         s.d = make_point(cx + t[3] * dx, cy + t[3] * dy);
      end else if (mode < 85) begin
         s.a = make_point(int'(coord_type'($urandom())), int'(coord_type'($urandom())));
         s.b = make_point(int'(coord_type'($urandom())), int'(coord_type'($urandom())));
         s.c = make_point(int'(coord_type'($urandom())), int'(coord_type'($urandom())));
         s.d = make_point(int'(coord_type'($urandom())), int'(coord_type'($urandom())));
         i = $urandom_range(0, 3);
         j = (i + $urandom_range(1, 3)) % 4;
         s.id[j] = s.id[i];
      end else begin
         s.a = make_point(edge_coord(), edge_coord());
         s.b = make_point(edge_coord(), edge_coord());
         s.c = make_point(edge_coord(), edge_coord());
         s.d = make_point(edge_coord(), edge_coord());
      end
      return s;
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   task automatic offer_pair(segment_pair_type s, bit known, bit want);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_pair(s);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_crosses.insert(pending_crosses.size(), known ? want : predict_crosses(s));
   endtask

   task automatic drain_results();
      int seen, gap;
      bit calm, want;
      seen = 0;
      calm = 1'b0;
      forever begin
         if (seen % 32 == 0) calm = ($urandom_range(0, 3) == 0);
         gap = calm ? 0 : $urandom_range(0, 5);
         if (seen == 150) gap = 60;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (pending_crosses.size() == 0) begin
            note_failure($sformatf("beat %0d: result with nothing pending, crosses %0b",
                                   seen, rsp_tdata[0]));
         end else begin
            want = pending_crosses.pop_front();
            if (rsp_tdata[0] !== want)
               note_failure($sformatf("beat %0d: crosses expected %0b, got %0b",
                                      seen, want, rsp_tdata[0]));
         end
         seen++;
      end
   endtask

   task automatic watch_idle();
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("timeout: %0d beats still pending", pending_crosses.size());
      $display("RESULT: ERROR");
      $finish;
   endtask

   initial begin
      add_row(row(1, 1, 1, 2, 3, 4, 0, 0, 10, 10, 0, 10, 10, 0));
      add_row(row(1, 1, 1, 2, 3, 4, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                  COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
      add_row(row(0, 0, 0, 65535, 1, 2, -7, 3, 9, -4, 0, -8, 2, 9));
      add_row(row(1, 0, 5, 5, 6, 7, 0, 0, 10, 10, 0, 10, 10, 0));
      add_row(row(1, 0, 5, 6, 5, 7, 0, 0, 10, 10, 0, 10, 10, 0));
      add_row(row(1, 0, 5, 6, 7, 5, 0, 0, 10, 10, 0, 10, 10, 0));
      add_row(row(1, 0, 5, 6, 6, 7, 0, 0, 10, 10, 0, 10, 10, 0));
      add_row(row(1, 0, 5, 6, 7, 6, 0, 0, 10, 10, 0, 10, 10, 0));
      add_row(row(1, 0, 65535, 0, 1, 1, 0, 0, 10, 10, 0, 10, 10, 0));
      add_row(row(0, 0, 1, 2, 3, 4, 0, 0, 10, 0, 0, 5, 10, 5));
      add_row(row(0, 0, 1, 2, 3, 4, 0, 0, 10, 0, 5, 0, 20, 0));
      add_row(row(0, 0, 1, 2, 3, 4, 0, 0, 4, 0, 5, 0, 9, 0));
      add_row(row(0, 0, 1, 2, 3, 4, 0, 0, 5, 5, 5, 5, 9, 9));
      add_row(row(0, 0, 1, 2, 3, 4, 0, 0, 6, 6, 3, 3, 3, 3));
      add_row(row(0, 0, 1, 2, 3, 4, 0, 0, 6, 6, 3, 4, 3, 4));
      add_row(row(0, 0, 1, 2, 3, 4, 0, 0, 10, 0, 5, 0, 5, 7));
      add_row(row(0, 0, 1, 2, 3, 4, 0, 0, 10, 0, 5, 1, 5, 7));
      add_row(row(0, 0, 1, 2, 3, 4, 2, 2, 2, 2, 2, 2, 2, 2));
      add_row(row(0, 0, 1, 2, 3, 4, 3, 0, 3, 0, 0, 0, 6, 0));
      add_row(row(0, 0, 1, 2, 3, 4, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                  -1, -1, 1, 1));
      add_row(row(0, 0, 1, 2, 3, 4, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      add_row(row(0, 0, 1, 2, 3, 4, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      add_row(row(0, 0, 1, 2, 3, 4, -5, -5, 5, 5, -5, 5, 5, -5));
      add_row(row(0, 0, 1, 2, 3, 4, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                  0, 0, COORD_MAX, COORD_MAX));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      fork
         drain_results();
         watch_idle();
      join_none

      foreach (directed_rows[k])
         offer_pair(directed_rows[k].pair, directed_rows[k].known, directed_rows[k].want);
      for (int k = 0; k < RANDOM_PAIRS; k++) begin
         if (k % 32 == 0) send_calm = ($urandom_range(0, 3) == 0);
         offer_pair(random_pair(), 1'b0, 1'b0);
      end
      req_tvalid <= 1'b0;

      while (pending_crosses.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
